### hw/rtl/bcd_up_down_display_counter_macros.svh
// assertion macros for the bcd up/down display counter
// used by the top level; no other dependencies
`ifndef BCD_UP_DOWN_DISPLAY_COUNTER_MACROS_SVH
`define BCD_UP_DOWN_DISPLAY_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BCDC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcd counter check failed");
`define BCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcd counter check failed");
`else
`define BCDC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/bcdc_pkg.sv
// shared constants and types of the bcd up/down display counter
// no dependencies
`timescale 1ns / 1ps

package bcdc_pkg;

  localparam int BTN_W     = 4;
  localparam int TPS_W     = 16;
  localparam int SEL_W     = 3;
  localparam int DIG_W     = 4;
  localparam int RES_LIMIT = 8;
  localparam int RES_IDX_W = $clog2(RES_LIMIT);
  localparam int CNT_W     = $clog2(RES_LIMIT + 1);

  localparam logic [TPS_W-1:0] TPS_RESET = 16'd300;
  localparam logic [DIG_W-1:0] DIG_MAX   = 4'd9;

  // button bit positions
  localparam int BTN_PLAY = 0;
  localparam int BTN_MODE = 1;
  localparam int BTN_STEP = 2;
  localparam int BTN_CLR  = 3;

  // one batch of display writes caused by a single request
  typedef struct packed {
    logic [RES_LIMIT-1:0][SEL_W-1:0] sel;
    logic [RES_LIMIT-1:0][DIG_W-1:0] val;
    logic [CNT_W-1:0]                count;
  } bcdc_batch_t;

endpackage

### hw/rtl/bcdc_in_if.sv
// input channel: button sample and tick per request
// depends on bcdc_pkg
`timescale 1ns / 1ps

interface bcdc_in_if import bcdc_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] button_levels;
  logic             tick;

  modport source (output valid, output button_levels, output tick, input ready);
  modport sink   (input valid, input button_levels, input tick, output ready);
endinterface

### hw/rtl/bcdc_out_if.sv
// result channel: one display digit write per transfer
// depends on bcdc_pkg
`timescale 1ns / 1ps

interface bcdc_out_if import bcdc_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] digit_select;
  logic [DIG_W-1:0] digit_value;
  logic             last_write;

  modport source (output valid, output digit_select, output digit_value, output last_write,
                  input ready);
  modport sink   (input valid, input digit_select, input digit_value, input last_write,
                  output ready);
endinterface

### hw/rtl/bcdc_core.sv
// counter state, button edge handling and write batch builder
// depends on bcdc_pkg and bcdc_in_if
`timescale 1ns / 1ps

module bcdc_core import bcdc_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [TPS_W-1:0] cfg_wr_data,
  bcdc_in_if.sink          in_ch,
  output logic             batch_vld,
  input  logic             batch_rdy,
  output bcdc_batch_t      batch
);

  localparam int SEG_W = $clog2(DIGIT_COUNT + 1);
  localparam int SUM_W = $clog2(3 * DIGIT_COUNT + RES_LIMIT + 1);

  typedef logic [DIG_W-1:0] digit_arr_t [DIGIT_COUNT];

  function automatic digit_arr_t bcd_step(digit_arr_t d, logic up);
    digit_arr_t q;
    logic       c;
    c = 1'b1;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      q[i] = d[i];
      if (c) begin
        if (up) begin
          q[i] = (d[i] >= DIG_MAX) ? '0 : d[i] + 1'b1;
          c    = d[i] >= DIG_MAX;
        end else begin
          q[i] = (d[i] == '0) ? DIG_MAX : d[i] - 1'b1;
          c    = d[i] == '0;
        end
      end
    end
    return q;
  endfunction

  // number of digits touched by one count step
  function automatic logic [SEG_W-1:0] step_len(digit_arr_t d, logic up);
    logic [SEG_W-1:0] n;
    logic             all;
    n   = SEG_W'(1);
    all = 1'b1;
    for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
      all = all & (up ? (d[i] >= DIG_MAX) : (d[i] == '0));
      if (all) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

  logic             in_vld_r;
  logic [BTN_W-1:0] lvl_r;
  logic             tick_r;
  digit_arr_t       digits_r;
  logic             run_r;
  logic             up_r;
  logic [BTN_W-1:0] prev_r;
  logic [TPS_W-1:0] tc_r;
  logic [TPS_W-1:0] tps_r;

  logic [BTN_W-1:0] fell;
  logic             run1;
  logic             up1;
  digit_arr_t       d1;
  digit_arr_t       d2;
  digit_arr_t       d3;
  logic [SEG_W-1:0] la;
  logic [SEG_W-1:0] lb;
  logic [SEG_W-1:0] lc;
  logic [SUM_W-1:0] total;
  logic [TPS_W-1:0] tc_inc;
  logic [TPS_W-1:0] tc_nxt;
  logic             tick_hit;
  logic             adv;

  always_comb begin
    fell  = prev_r & ~lvl_r;
    run1  = run_r ^ fell[BTN_PLAY];
    up1   = up_r ^ fell[BTN_MODE];

    d1 = digits_r;
    la = '0;
    if (fell[BTN_STEP] && !run1) begin
      d1 = bcd_step(digits_r, up1);
      la = step_len(digits_r, up1);
    end

    d2 = d1;
    lb = '0;
    if (fell[BTN_CLR]) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        d2[i] = up1 ? '0 : DIG_MAX;
      end
      lb = SEG_W'(DIGIT_COUNT);
    end

    tc_inc   = tc_r + 1'b1;
    tc_nxt   = tc_r;
    tick_hit = 1'b0;
    if (run1 && tick_r) begin
      tc_nxt = tc_inc;
      if (tc_inc >= tps_r) begin
        tc_nxt   = '0;
        tick_hit = 1'b1;
      end
    end

    d3 = d2;
    lc = '0;
    if (tick_hit) begin
      d3 = bcd_step(d2, up1);
      lc = step_len(d2, up1);
    end

    total = SUM_W'(la) + SUM_W'(lb) + SUM_W'(lc);

    // step writes run downward, clear writes upward, tick step writes downward
    batch = '0;
    for (int k = 0; k < RES_LIMIT; k++) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (i < int'(la) && k == int'(la) - 1 - i) begin
          batch.sel[k] = SEL_W'(i + 1);
          batch.val[k] = d1[i];
        end
        if (i < int'(lb) && k == int'(la) + i) begin
          batch.sel[k] = SEL_W'(i + 1);
          batch.val[k] = d2[i];
        end
        if (i < int'(lc) && k == int'(la) + int'(lb) + int'(lc) - 1 - i) begin
          batch.sel[k] = SEL_W'(i + 1);
          batch.val[k] = d3[i];
        end
      end
    end
    batch.count = (total > SUM_W'(RES_LIMIT)) ? CNT_W'(RES_LIMIT) : CNT_W'(total);
  end

  assign adv         = in_vld_r && ((total == '0) || batch_rdy);
  assign batch_vld   = in_vld_r && (total != '0);
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      run_r    <= 1'b0;
      up_r     <= 1'b1;
      prev_r   <= '1;
      tc_r     <= '0;
      tps_r    <= TPS_RESET;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digits_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        tps_r <= cfg_wr_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        run_r    <= run1;
        up_r     <= up1;
        prev_r   <= lvl_r;
        tc_r     <= tc_nxt;
        digits_r <= d3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      lvl_r  <= in_ch.button_levels;
      tick_r <= in_ch.tick;
    end
  end

endmodule

### hw/rtl/bcdc_serializer.sv
// holds one write batch and hands it out one write per cycle while the output is ready
// depends on bcdc_pkg and bcdc_out_if
`timescale 1ns / 1ps

module bcdc_serializer import bcdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        batch_vld,
  output logic        batch_rdy,
  input  bcdc_batch_t batch,
  bcdc_out_if.source  out_ch
);

  logic                 bat_vld_r;
  bcdc_batch_t          bat_r;
  logic [RES_IDX_W-1:0] idx_r;
  logic                 out_vld_r;
  logic [SEL_W-1:0]     out_sel_r;
  logic [DIG_W-1:0]     out_val_r;
  logic                 out_last_r;

  logic out_free;
  logic move;
  logic is_last;

  assign out_free  = !out_vld_r || out_ch.ready;
  assign move      = bat_vld_r && out_free;
  assign is_last   = (CNT_W'(idx_r) + 1'b1) == bat_r.count;
  assign batch_rdy = !bat_vld_r || (move && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bat_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (batch_vld && batch_rdy) begin
        bat_vld_r <= 1'b1;
        idx_r     <= '0;
      end else if (move) begin
        idx_r <= idx_r + 1'b1;
        if (is_last) begin
          bat_vld_r <= 1'b0;
        end
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch_vld && batch_rdy) begin
      bat_r <= batch;
    end
    if (move) begin
      out_sel_r  <= bat_r.sel[idx_r];
      out_val_r  <= bat_r.val[idx_r];
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.digit_select = out_sel_r;
  assign out_ch.digit_value  = out_val_r;
  assign out_ch.last_write   = out_last_r;

endmodule

### hw/rtl/bcd_up_down_display_counter.sv
// bcd up/down display counter: a request is taken into an input register, its
// whole batch of display writes is built from it and loaded into the serializer;
// the load waits while the serializer is busy; writes leave one per cycle while ready
// a new request is taken once the previous batch is loaded or had no writes; 8 writes at most
// synchronous active-low reset clears digits, run flag, tick count, sets up mode, period 300
`timescale 1ns / 1ps
`include "bcd_up_down_display_counter_macros.svh"

module bcd_up_down_display_counter import bcdc_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [TPS_W-1:0] cfg_wr_data,
  bcdc_in_if.sink          in_ch,
  bcdc_out_if.source       out_ch
);

  logic        batch_vld;
  logic        batch_rdy;
  bcdc_batch_t batch;

  bcdc_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .batch_vld   (batch_vld),
    .batch_rdy   (batch_rdy),
    .batch       (batch)
  );

  bcdc_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .batch_vld (batch_vld),
    .batch_rdy (batch_rdy),
    .batch     (batch),
    .out_ch    (out_ch)
  );

  `BCDC_ASSERT_IMPLIES(a_batch_count, clk, rst_n, batch_vld, (batch.count != '0) && (batch.count <= CNT_W'(RES_LIMIT)))
  `BCDC_ASSERT_IMPLIES(a_digit_bcd, clk, rst_n, out_ch.valid, out_ch.digit_value <= DIG_MAX)
  `BCDC_ASSERT_IMPLIES(a_select_nonzero, clk, rst_n, out_ch.valid && (DIGIT_COUNT < RES_LIMIT), out_ch.digit_select != '0)

endmodule
